// ===== rtl/pwc_pkg.sv =====
// Shared types and constants for the power window controller.
// No dependencies; imported by the channel interfaces and all RTL modules.
package pwc_pkg;

  localparam int unsigned THR_W  = 16;
  localparam int unsigned DUTY_W = 7;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam logic [THR_W-1:0]  DECIDE_TICKS_RST  = 16'd200;
  localparam logic [THR_W-1:0]  REVERSE_TICKS_RST = 16'd500;
  localparam logic [DUTY_W-1:0] DRIVE_DUTY_RST    = 7'd25;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_DECIDE    = 3'd1,
    MODE_ONE_TOUCH = 3'd2,
    MODE_HELD      = 3'd3,
    MODE_REVERSE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_OPEN  = 2'd1,
    DIR_CLOSE = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    EV_DRIVER_OPEN     = 3'd0,
    EV_DRIVER_CLOSE    = 3'd1,
    EV_PASSENGER_OPEN  = 3'd2,
    EV_PASSENGER_CLOSE = 3'd3,
    EV_SAFETY          = 3'd4,
    EV_LOCK            = 3'd5
  } event_code_t;

  typedef enum logic [1:0] {
    CFG_DECIDE_TICKS  = 2'd0,
    CFG_REVERSE_TICKS = 2'd1,
    CFG_DRIVE_DUTY    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic driver_open_btn;
    logic driver_close_btn;
    logic passenger_open_btn;
    logic passenger_close_btn;
    logic at_open_limit;
    logic at_close_limit;
    logic lock_on;
    logic safety_hit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        motor_direction;
    logic [DUTY_W-1:0] duty_percent;
    logic              event_valid;
    logic [2:0]        event_code;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  decide_ticks;
    logic [THR_W-1:0]  reverse_ticks;
    logic [DUTY_W-1:0] drive_duty;
  } cfg_regs_t;

endpackage

// ===== rtl/pwc_if.sv =====
// Valid/ready channel interfaces for the power window controller.
// Depends on pwc_pkg for the payload types.
interface pwc_in_if;
  logic               valid;
  logic               ready;
  pwc_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pwc_out_if;
  logic               valid;
  logic               ready;
  pwc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/power_window_controller_unit.sv =====
// A result passes through the input register, then the result register, before it
// is valid on out_ch; while out_ch.ready is low it can be held in the input register.
// Throughput: one transaction per cycle while results are taken from out_ch; the result
// register lets one new item enter while an earlier result waits on out_ch.ready.
// Reset (rst_n low, synchronous): channels empty, window idle, registers at defaults.
// Depends on pwc_pkg, pwc_if and pwc_core.
module power_window_controller_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  pwc_in_if.sink     in_ch,
  pwc_out_if.source  out_ch,
  pwc_cfg_if.sink    cfg_ch
);
  import pwc_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  cfg_regs_t cfg_r;
  out_item_t result;
  logic      step;

  assign step         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || step;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  pwc_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (step) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_item_r <= in_ch.item;
    if (step) out_item_r <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decide_ticks  <= DECIDE_TICKS_RST;
      cfg_r.reverse_ticks <= REVERSE_TICKS_RST;
      cfg_r.drive_duty    <= DRIVE_DUTY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_index_t'(cfg_ch.index))
        CFG_DECIDE_TICKS:  cfg_r.decide_ticks  <= cfg_ch.data;
        CFG_REVERSE_TICKS: cfg_r.reverse_ticks <= cfg_ch.data;
        CFG_DRIVE_DUTY:    cfg_r.drive_duty    <= cfg_ch.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pwc_core.sv =====
// Window control state machine: one tick per step, result is combinational.
// Depends on pwc_pkg.
module pwc_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pwc_pkg::in_item_t   item,
  input  pwc_pkg::cfg_regs_t  cfg,
  output pwc_pkg::out_item_t  result
);
  import pwc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'(CNT_MAX);

  mode_t                  mode_r, mode_nxt;
  logic                   owner_r, owner_nxt;
  logic                   rdir_r, rdir_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic                   lock_before_r, lock_before_nxt;

  logic [CMP_W-1:0]       dec_thr, rev_thr, dec_ext, rev_ext;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [3:0]             btn;
  logic                   pressed;
  logic                   lim;
  logic                   go_on;
  mode_t                  m;
  dir_t                   dir;
  logic                   ev_valid;
  event_code_t            ev_code;
  logic [DUTY_W-1:0]      duty_lim;

  assign dec_ext = CMP_W'(cfg.decide_ticks);
  assign rev_ext = CMP_W'(cfg.reverse_ticks);
  assign dec_thr = (dec_ext > CNT_MAX_EXT) ? CNT_MAX_EXT : dec_ext;
  assign rev_thr = (rev_ext > CNT_MAX_EXT) ? CNT_MAX_EXT : rev_ext;
  assign tick_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign btn = {item.passenger_close_btn, item.passenger_open_btn,
                item.driver_close_btn, item.driver_open_btn};
  assign pressed = btn[{owner_r, rdir_r}];
  assign lim = rdir_r ? item.at_close_limit : item.at_open_limit;
  assign duty_lim = (cfg.drive_duty > DUTY_MAX) ? DUTY_MAX : cfg.drive_duty;

  always_comb begin
    mode_nxt        = mode_r;
    owner_nxt       = owner_r;
    rdir_nxt        = rdir_r;
    tick_nxt        = tick_r;
    lock_before_nxt = lock_before_r;
    dir             = DIR_STOP;
    ev_valid        = 1'b0;
    ev_code         = EV_DRIVER_OPEN;
    go_on           = 1'b1;
    m               = mode_r;

    if (item.safety_hit) begin
      mode_nxt = MODE_REVERSE;
      tick_nxt = COUNT_WIDTH'(1);
      dir      = DIR_CLOSE;
    end else begin
      unique case (mode_r)
        MODE_REVERSE: begin
          if (CMP_W'(tick_r) >= rev_thr) begin
            mode_nxt = MODE_IDLE;
            ev_valid = 1'b1;
            ev_code  = EV_SAFETY;
          end else begin
            tick_nxt = tick_inc;
            dir      = DIR_CLOSE;
          end
        end
        MODE_DECIDE, MODE_ONE_TOUCH, MODE_HELD: begin
          if (owner_r && item.lock_on) begin
            mode_nxt = MODE_IDLE;
            go_on    = 1'b0;
          end else if (mode_r == MODE_DECIDE) begin
            tick_nxt = tick_inc;
            if (CMP_W'(tick_inc) >= dec_thr) begin
              m = pressed ? MODE_HELD : MODE_ONE_TOUCH;
            end else begin
              go_on = 1'b0;
            end
          end
          if (go_on) begin
            if (lim || (m == MODE_HELD && !pressed)) begin
              mode_nxt = MODE_IDLE;
              ev_valid = 1'b1;
              ev_code  = event_code_t'({1'b0, owner_r, rdir_r});
            end else begin
              mode_nxt = m;
              dir      = rdir_r ? DIR_CLOSE : DIR_OPEN;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          priority if (btn[0]) begin
            {owner_nxt, rdir_nxt} = 2'd0;
            mode_nxt = MODE_DECIDE;
            tick_nxt = '0;
          end else if (btn[1]) begin
            {owner_nxt, rdir_nxt} = 2'd1;
            mode_nxt = MODE_DECIDE;
            tick_nxt = '0;
          end else if (btn[2] && !item.lock_on) begin
            {owner_nxt, rdir_nxt} = 2'd2;
            mode_nxt = MODE_DECIDE;
            tick_nxt = '0;
          end else if (btn[3] && !item.lock_on) begin
            {owner_nxt, rdir_nxt} = 2'd3;
            mode_nxt = MODE_DECIDE;
            tick_nxt = '0;
          end
        end
      endcase
    end

    if (!item.lock_on) begin
      lock_before_nxt = 1'b0;
    end else if (!lock_before_r && !ev_valid) begin
      ev_valid        = 1'b1;
      ev_code         = EV_LOCK;
      lock_before_nxt = 1'b1;
    end

    result.motor_direction = dir;
    result.duty_percent    = (dir == DIR_STOP) ? '0 : duty_lim;
    result.event_valid     = ev_valid;
    result.event_code      = ev_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      owner_r       <= 1'b0;
      rdir_r        <= 1'b0;
      tick_r        <= '0;
      lock_before_r <= 1'b0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      owner_r       <= owner_nxt;
      rdir_r        <= rdir_nxt;
      tick_r        <= tick_nxt;
      lock_before_r <= lock_before_nxt;
    end
  end

endmodule

// ===== rtl/pwc_checker.sv =====
// Port-level checks on the power window controller result channel.
// Depends on pwc_pkg; bound to power_window_controller_unit.
module pwc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] motor_direction,
  input logic [6:0] duty_percent,
  input logic       event_valid,
  input logic [2:0] event_code
);
  import pwc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (motor_direction == DIR_STOP) |-> (duty_percent == '0))
    else $error("duty applied with motor stopped");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((event_valid || event_code == EV_DRIVER_OPEN)
                   && event_code <= EV_LOCK && motor_direction != 2'd3
                   && duty_percent <= DUTY_MAX))
    else $error("malformed result");

endmodule

bind power_window_controller_unit pwc_checker u_pwc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .motor_direction (out_ch.item.motor_direction),
  .duty_percent    (out_ch.item.duty_percent),
  .event_valid     (out_ch.item.event_valid),
  .event_code      (out_ch.item.event_code)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for power_window_controller_unit: tick stimulus, register writes,
// and an in-bench window model that checks every result transaction in order.
// Depends on pwc_pkg, the pwc_if channel interfaces and the controller RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pwc_pkg::*;

  localparam int COUNT_W = 16;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  pwc_in_if  in_ch();
  pwc_out_if out_ch();
  pwc_cfg_if cfg_ch();

  power_window_controller_unit #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // window model state and register copies
  logic [THR_W-1:0]   thr_decide  = DECIDE_TICKS_RST;
  logic [THR_W-1:0]   thr_reverse = REVERSE_TICKS_RST;
  logic [DUTY_W-1:0]  duty_reg    = DRIVE_DUTY_RST;
  mode_t              win_mode    = MODE_IDLE;
  logic               req_passenger = 1'b0;
  logic               req_close     = 1'b0;
  logic [COUNT_W-1:0] tick_cnt      = '0;
  logic               lock_seen     = 1'b0;

  in_item_t  pending_ticks[$];
  out_item_t window_results[$];
  out_item_t want;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  in_taken;
  int  mismatches = 0;
  int  n_checked  = 0;
  int  n_moving   = 0;
  int  n_events   = 0;

  function automatic out_item_t predict_tick(in_item_t t);
    logic [3:0]  btn;
    logic        pressed;
    logic        lim;
    logic        go_on;
    dir_t        dir;
    logic        ev_v;
    event_code_t ev_c;
    out_item_t   r;
    btn = {t.passenger_close_btn, t.passenger_open_btn,
           t.driver_close_btn, t.driver_open_btn};
    dir   = DIR_STOP;
    ev_v  = 1'b0;
    ev_c  = EV_DRIVER_OPEN;
    go_on = 1'b1;
    if (t.safety_hit) begin
      win_mode = MODE_REVERSE;
      tick_cnt = 1;
      dir      = DIR_CLOSE;
    end else if (win_mode == MODE_REVERSE) begin
      if (tick_cnt >= thr_reverse) begin
        win_mode = MODE_IDLE;
        ev_v     = 1'b1;
        ev_c     = EV_SAFETY;
      end else begin
        if (tick_cnt != '1) tick_cnt++;
        dir = DIR_CLOSE;
      end
    end else if (win_mode == MODE_DECIDE || win_mode == MODE_ONE_TOUCH ||
                 win_mode == MODE_HELD) begin
      pressed = btn[{req_passenger, req_close}];
      if (req_passenger && t.lock_on) begin
        win_mode = MODE_IDLE;
        go_on    = 1'b0;
      end else if (win_mode == MODE_DECIDE) begin
        if (tick_cnt != '1) tick_cnt++;
        if (tick_cnt >= thr_decide) win_mode = pressed ? MODE_HELD : MODE_ONE_TOUCH;
        else go_on = 1'b0;
      end
      if (go_on) begin
        lim = req_close ? t.at_close_limit : t.at_open_limit;
        if (lim || (win_mode == MODE_HELD && !pressed)) begin
          win_mode = MODE_IDLE;
          ev_v     = 1'b1;
          ev_c     = event_code_t'({1'b0, req_passenger, req_close});
        end else begin
          dir = req_close ? DIR_CLOSE : DIR_OPEN;
        end
      end
    end else begin
      win_mode = MODE_IDLE;
      for (int k = 0; k < 4; k++) begin
        if (win_mode == MODE_IDLE && btn[k] && !(k >= 2 && t.lock_on)) begin
          req_passenger = (k >= 2);
          req_close     = k[0];
          win_mode      = MODE_DECIDE;
          tick_cnt      = '0;
        end
      end
    end

    if (!t.lock_on) begin
      lock_seen = 1'b0;
    end else if (!lock_seen && !ev_v) begin
      ev_v      = 1'b1;
      ev_c      = EV_LOCK;
      lock_seen = 1'b1;
    end

    r.motor_direction = dir;
    r.duty_percent    = (dir == DIR_STOP) ? '0 : ((duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg);
    r.event_valid     = ev_v;
    r.event_code      = ev_c;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // tick driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.item  <= pending_ticks.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_taken) window_results.push_back(predict_tick(in_ch.item));
      if (out_ch.valid && out_ch.ready) begin
        if (window_results.size() == 0) begin
          $error("result transaction with nothing expected: %p", out_ch.item);
          mismatches++;
        end else begin
          want = window_results.pop_front();
          check_field("motor_direction", want.motor_direction, out_ch.item.motor_direction);
          check_field("duty_percent", want.duty_percent, out_ch.item.duty_percent);
          check_field("event_valid", want.event_valid, out_ch.item.event_valid);
          check_field("event_code", want.event_code, out_ch.item.event_code);
          n_checked++;
          if (want.motor_direction != DIR_STOP) n_moving++;
          if (want.event_valid) n_events++;
        end
      end
    end
  end

  task automatic push_tick(logic [3:0] btns, logic [1:0] lims, logic lock, logic hit);
    in_item_t it;
    it.driver_open_btn     = btns[0];
    it.driver_close_btn    = btns[1];
    it.passenger_open_btn  = btns[2];
    it.passenger_close_btn = btns[3];
    it.at_open_limit       = lims[0];
    it.at_close_limit      = lims[1];
    it.lock_on             = lock;
    it.safety_hit          = hit;
    pending_ticks.push_back(it);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_DECIDE_TICKS:  thr_decide  = val;
      CFG_REVERSE_TICKS: thr_reverse = val;
      CFG_DRIVE_DUTY:    duty_reg    = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_window();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || window_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // press sequences with random timing around the decision point, plus noise ticks
  task automatic gen_presses(int n);
    int         target;
    int         hold;
    int         run;
    int         span;
    logic [3:0] press;
    logic [3:0] extra;
    logic [1:0] lim;
    logic       keep;
    logic       lock;
    in_item_t   junk;
    target = pending_ticks.size() + n;
    span   = (thr_decide > 8) ? 8 : thr_decide;
    lock   = 1'b0;
    while (pending_ticks.size() < target) begin
      if ($urandom_range(99) < 75) begin
        press = 4'b0001 << $urandom_range(3);
        extra = ($urandom_range(4) == 0) ? 4'($urandom) : 4'b0000;
        if ($urandom_range(9) == 0) lock = ~lock;
        hold = $urandom_range(span + 1);
        keep = $urandom_range(1);
        run  = $urandom_range(10);
        lim  = (press[1] || press[3]) ? 2'b10 : 2'b01;
        for (int i = 0; i <= hold; i++)
          push_tick(press | extra, 2'b00, lock, $urandom_range(49) == 0);
        for (int i = 0; i < run; i++) begin
          if ($urandom_range(29) == 0) lock = ~lock;
          push_tick(keep ? press : 4'b0000, ($urandom_range(19) == 0) ? 2'($urandom) : 2'b00,
                    lock, $urandom_range(49) == 0);
        end
        push_tick((keep && $urandom_range(1)) ? press : 4'b0000,
                  ($urandom_range(3) == 0) ? 2'b00 : lim, lock, 1'b0);
        repeat ($urandom_range(2)) push_tick(4'b0000, 2'b00, lock, 1'b0);
      end else begin
        junk = in_item_t'(8'($urandom));
        junk.safety_hit = ($urandom_range(9) == 0);
        pending_ticks.push_back(junk);
      end
    end
  endtask

  task automatic run_phase(logic [15:0] dec, logic [15:0] rev, logic [15:0] duty,
                           int send_pct, int stall_pct, int n);
    write_reg(CFG_DECIDE_TICKS, dec);
    write_reg(CFG_REVERSE_TICKS, rev);
    write_reg(CFG_DRIVE_DUTY, duty);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    gen_presses(n);
    drain_window();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_DECIDE_TICKS;
    cfg_ch.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: safety reversal and lock edge
    push_tick(4'b0000, 2'b00, 1'b0, 1'b1);
    push_tick(4'b0000, 2'b00, 1'b1, 1'b0);
    drain_window();

    write_reg(CFG_DECIDE_TICKS, 16'd2);
    write_reg(CFG_REVERSE_TICKS, 16'd3);
    write_reg(CFG_DRIVE_DUTY, 16'h00FF);
    push_tick(4'b0000, 2'b00, 1'b1, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b1, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    // all buttons: driver open wins, then one-touch to the open limit
    push_tick(4'b1111, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b01, 1'b0, 1'b0);
    // driver close held, then released
    push_tick(4'b0010, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0010, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0010, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    // passenger blocked by lock, then limit already reached on the decision tick
    push_tick(4'b0100, 2'b00, 1'b1, 1'b0);
    push_tick(4'b1000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b1000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b1000, 2'b10, 1'b0, 1'b0);
    // lock cancels a passenger press
    push_tick(4'b0100, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0100, 2'b00, 1'b1, 1'b0);
    // safety aborts a press, restarts reversal, lock edge deferred past safety event
    push_tick(4'b0001, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b1);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b1);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b0, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b1, 1'b0);
    push_tick(4'b0000, 2'b00, 1'b1, 1'b0);
    drain_window();

    run_phase(16'd1, 16'd1, 16'd0, 0, 0, 250);
    run_phase(16'd4, 16'd6, 16'd50, 51, 0, 300);
    run_phase(16'd0, 16'd0, 16'h00FF, 0, 51, 250);
    run_phase(16'd6, 16'd9, 16'd100, 8, 8, 300);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFF81, 0, 0, 250);

    repeat (10) @(negedge clk);
    $display("Checked %0d ticks across seven register settings and four flow-control mixes",
             n_checked);
    $display("Motor driven on %0d ticks, %0d completion events reported", n_moving, n_events);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", window_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
